### hw/rtl/s5scan_pkg.sv
package s5scan_pkg;

    localparam int MAX_TABLE_BYTES = 1048576;
    localparam int HEADER_BYTES    = 36;

    // Offset counter saturates at MAX_TABLE_BYTES; resume point can reach MAX + 4
    localparam int OFS_W = $clog2(MAX_TABLE_BYTES + 8);

    localparam logic [OFS_W-1:0] MAX_OFS = OFS_W'(MAX_TABLE_BYTES);
    // A window ending at offset o starts at o - 3, so search bounds are kept as o bounds
    localparam logic [OFS_W-1:0] SEARCH_FROM_RST = OFS_W'(HEADER_BYTES + 3);
    localparam logic [OFS_W-1:0] SIG_LAST_OFS    = OFS_W'(3);
    localparam logic [OFS_W-1:0] SIG_BYTES       = OFS_W'(4);
    localparam logic [OFS_W-1:0] RESUME_PKG      = OFS_W'(4);
    localparam logic [OFS_W-1:0] RESUME_LEN      = OFS_W'(5);

    localparam logic [31:0] SIG_WORD    = 32'h5444_5344;  // "DSDT", first byte lowest
    localparam logic [31:0] S5_WORD     = 32'h5F53_355F;  // "_S5_", first byte highest
    localparam logic [7:0]  PKG_OP      = 8'h12;
    localparam logic [7:0]  BYTE_PREFIX = 8'h0A;
    localparam logic [7:0]  LEN_MIN     = 8'd4;

    typedef enum logic [2:0] {
        PH_SEARCH   = 3'd0,
        PH_WANT_PKG = 3'd1,
        PH_WANT_LEN = 3'd2,
        PH_SKIP     = 3'd3,
        PH_PFX_A    = 3'd4,
        PH_READ_A   = 3'd5,
        PH_PFX_B    = 3'd6,
        PH_READ_B   = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_BAD_SIG   = 3'd1,
        ST_BAD_SUM   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_TOO_LONG  = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_beat;

    typedef struct packed {
        logic [7:0] sleep_type_b;
        logic [7:0] sleep_type_a;
        t_status    status;
    } t_result;

endpackage

### hw/rtl/s5scan_in_stage.sv
module s5scan_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  s5scan_pkg::t_beat i_beat,
    input  logic              i_out_free,
    output logic              o_step,
    output s5scan_pkg::t_beat o_beat
);
    import s5scan_pkg::*;

    logic  r_valid;
    t_beat r_beat;

    // A byte without last never waits on the result side
    assign o_step  = r_valid && (!r_beat.last || i_out_free);
    assign o_ready = !r_valid || o_step;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

### hw/rtl/s5scan_core.sv
module s5scan_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  s5scan_pkg::t_beat   i_beat,
    output s5scan_pkg::t_result o_result
);
    import s5scan_pkg::*;

    logic [OFS_W-1:0] r_offset, n_offset;
    logic [7:0]       r_sum, n_sum;
    logic             r_sig_ok, n_sig_ok;
    logic [31:0]      r_recent, n_recent;
    t_phase           r_phase, n_phase;
    logic [OFS_W-1:0] r_search_from, n_search_from;
    logic             r_found, n_found;
    logic [7:0]       r_type_a, n_type_a;
    logic [7:0]       r_type_b, n_type_b;

    logic [7:0] b;
    logic       too_long;
    logic [7:0] sig_byte;

    assign b        = i_beat.data;
    assign too_long = r_offset >= MAX_OFS;
    assign sig_byte = SIG_WORD[{r_offset[1:0], 3'b000} +: 8];

    always_comb begin
        n_offset      = r_offset;
        n_sum         = r_sum + b;
        n_sig_ok      = r_sig_ok;
        n_recent      = r_recent;
        n_phase       = r_phase;
        n_search_from = r_search_from;
        n_found       = r_found;
        n_type_a      = r_type_a;
        n_type_b      = r_type_b;

        if (!too_long) begin
            if (r_offset < SIG_BYTES && b != sig_byte) begin
                n_sig_ok = 1'b0;
            end
            n_recent = {r_recent[23:0], b};
            n_offset = r_offset + 1'b1;

            case (r_phase)
                PH_SEARCH: begin
                    if (!r_found && r_offset >= r_search_from && n_recent == S5_WORD) begin
                        n_phase = PH_WANT_PKG;
                    end
                end
                PH_WANT_PKG: begin
                    if (b == PKG_OP) begin
                        n_phase = PH_WANT_LEN;
                    end else begin
                        n_search_from = r_offset + RESUME_PKG;
                        n_phase       = PH_SEARCH;
                    end
                end
                PH_WANT_LEN: begin
                    if (b >= LEN_MIN) begin
                        n_found = 1'b1;
                        n_phase = PH_SKIP;
                    end else begin
                        n_search_from = r_offset + RESUME_LEN;
                        n_phase       = PH_SEARCH;
                    end
                end
                PH_SKIP:   n_phase = PH_PFX_A;
                PH_PFX_A:  n_phase = (b == BYTE_PREFIX) ? PH_READ_A : PH_SEARCH;
                PH_READ_A: begin
                    n_type_a = b;
                    n_phase  = PH_PFX_B;
                end
                PH_PFX_B:  n_phase = (b == BYTE_PREFIX) ? PH_READ_B : PH_SEARCH;
                PH_READ_B: begin
                    n_type_b = b;
                    n_phase  = PH_SEARCH;
                end
                default:   n_phase = PH_SEARCH;
            endcase
        end
    end

    // Result from the updated state; priority: signature, length, checksum, match
    always_comb begin
        o_result = '0;
        if (!n_sig_ok || r_offset < SIG_LAST_OFS) begin
            o_result.status = ST_BAD_SIG;
        end else if (too_long) begin
            o_result.status = ST_TOO_LONG;
        end else if (n_sum != 8'd0) begin
            o_result.status = ST_BAD_SUM;
        end else if (n_found) begin
            o_result.status       = ST_FOUND;
            o_result.sleep_type_a = n_type_a;
            o_result.sleep_type_b = n_type_b;
        end else begin
            o_result.status = ST_NOT_FOUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_beat.last)) begin
            r_offset      <= '0;
            r_sum         <= '0;
            r_sig_ok      <= 1'b1;
            r_recent      <= '0;
            r_phase       <= PH_SEARCH;
            r_search_from <= SEARCH_FROM_RST;
            r_found       <= 1'b0;
            r_type_a      <= '0;
            r_type_b      <= '0;
        end else if (i_step) begin
            r_offset      <= n_offset;
            r_sum         <= n_sum;
            r_sig_ok      <= n_sig_ok;
            r_recent      <= n_recent;
            r_phase       <= n_phase;
            r_search_from <= n_search_from;
            r_found       <= n_found;
            r_type_a      <= n_type_a;
            r_type_b      <= n_type_b;
        end
    end

endmodule

### hw/rtl/s5scan_out_stage.sv
module s5scan_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  s5scan_pkg::t_result i_result,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_ready,
    output s5scan_pkg::t_result o_result
);
    import s5scan_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

### hw/rtl/acpi_s5_sleep_type_scanner_unit.sv
// Channel   Direction  Handshake                         Payload
// s_axis    in         i_s_axis_tvalid / o_s_axis_tready tdata: data_byte; tlast: last_byte
// m_axis    out        o_m_axis_tvalid / i_m_axis_tready tdata: status, type A, type B
//
// One table byte per cycle unless a last byte waits; a byte passes an input register,
// then the scan state update, and a last byte writes the result register, so the
// result is registered and valid only after its last byte leaves the input register.
// Only a last byte waits on a full result register; other bytes keep flowing.
// i_rst_n is synchronous, active low; the scan state also returns to reset after
// each last byte, so the next table starts clean.
module acpi_s5_sleep_type_scanner_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata    // [2:0] status, [10:3] sleep_type_a,
                                          // [18:11] sleep_type_b, [23:19] zero
);
    import s5scan_pkg::*;

    t_beat   in_beat;
    t_beat   core_beat;
    t_result core_result;
    t_result out_result;
    logic    step;
    logic    out_free;

    assign in_beat.data = i_s_axis_tdata;
    assign in_beat.last = i_s_axis_tlast;

    s5scan_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_beat     (in_beat),
        .i_out_free (out_free),
        .o_step     (step),
        .o_beat     (core_beat)
    );

    s5scan_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_beat   (core_beat),
        .o_result (core_result)
    );

    s5scan_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step && core_beat.last),
        .i_result (core_result),
        .o_free   (out_free),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (out_result)
    );

    assign o_m_axis_tdata = {5'b0, out_result};

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import s5scan_pkg::*;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int MAX_SHOWN    = 10;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_PCT     = 7;

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;

    bit          src_idle_on = 1'b1;
    bit          snk_idle_on = 1'b1;
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;

    // Scan state mirrored per table
    logic [OFS_W-1:0] scan_ofs;
    logic [7:0]       scan_sum;
    logic             sig_good;
    logic [31:0]      window;
    t_phase           phase;
    logic [OFS_W-1:0] resume_ofs;
    logic             s5_found;
    logic [7:0]       type_a;
    logic [7:0]       type_b;

    t_result    sleep_reports[$];
    logic [7:0] tbl[$];

    acpi_s5_sleep_type_scanner_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void clear_scan();
        scan_ofs   = '0;
        scan_sum   = 8'd0;
        sig_good   = 1'b1;
        window     = 32'd0;
        phase      = PH_SEARCH;
        resume_ofs = OFS_W'(HEADER_BYTES);
        s5_found   = 1'b0;
        type_a     = 8'd0;
        type_b     = 8'd0;
    endfunction

    // Advance the scan by one accepted byte; queue the report on the last byte
    function automatic void scan_table_byte(input logic [7:0] b, input logic last);
        logic [OFS_W-1:0] o;
        logic             over;
        t_result          r;
        o    = scan_ofs;
        over = (o >= MAX_OFS);
        scan_sum = scan_sum + b;
        if (!over) begin
            if (o < SIG_BYTES) begin
                if (b != SIG_WORD[8*o +: 8])
                    sig_good = 1'b0;
            end
            window = {window[23:0], b};
            case (phase)
                PH_SEARCH: begin
                    // window start is o - 3
                    if (!s5_found && o >= SIG_LAST_OFS && o - 3 >= resume_ofs &&
                        o - 3 >= HEADER_BYTES && window == S5_WORD)
                        phase = PH_WANT_PKG;
                end
                PH_WANT_PKG: begin
                    if (b == PKG_OP) begin
                        phase = PH_WANT_LEN;
                    end else begin
                        resume_ofs = OFS_W'(o + 1);
                        phase      = PH_SEARCH;
                    end
                end
                PH_WANT_LEN: begin
                    if (b >= LEN_MIN) begin
                        s5_found = 1'b1;
                        phase    = PH_SKIP;
                    end else begin
                        resume_ofs = OFS_W'(o + 2);
                        phase      = PH_SEARCH;
                    end
                end
                PH_SKIP:   phase = PH_PFX_A;
                PH_PFX_A:  phase = (b == BYTE_PREFIX) ? PH_READ_A : PH_SEARCH;
                PH_READ_A: begin
                    type_a = b;
                    phase  = PH_PFX_B;
                end
                PH_PFX_B:  phase = (b == BYTE_PREFIX) ? PH_READ_B : PH_SEARCH;
                PH_READ_B: begin
                    type_b = b;
                    phase  = PH_SEARCH;
                end
                default:   phase = PH_SEARCH;
            endcase
            scan_ofs = OFS_W'(o + 1);
        end
        if (last) begin
            if (!sig_good || o < SIG_LAST_OFS)
                r.status = ST_BAD_SIG;
            else if (over)
                r.status = ST_TOO_LONG;
            else if (scan_sum != 8'd0)
                r.status = ST_BAD_SUM;
            else if (s5_found)
                r.status = ST_FOUND;
            else
                r.status = ST_NOT_FOUND;
            r.sleep_type_a = (r.status == ST_FOUND) ? type_a : 8'd0;
            r.sleep_type_b = (r.status == ST_FOUND) ? type_b : 8'd0;
            sleep_reports.push_back(r);
            clear_scan();
        end
    endfunction

    function automatic void log_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_SHOWN)
            $display("%0t ns: %s", $time, msg);
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = t_result'(m_tdata[18:0]);
            if (sleep_reports.size() == 0) begin
                log_mismatch($sformatf("unexpected result status=%0d a=%02h b=%02h",
                                       got.status, got.sleep_type_a, got.sleep_type_b));
            end else begin
                want = sleep_reports.pop_front();
                if (got.status != want.status || got.sleep_type_a != want.sleep_type_a ||
                    got.sleep_type_b != want.sleep_type_b)
                    log_mismatch($sformatf(
                        "exp status=%0d a=%02h b=%02h, got status=%0d a=%02h b=%02h",
                        want.status, want.sleep_type_a, want.sleep_type_b,
                        got.status, got.sleep_type_a, got.sleep_type_b));
            end
        end
    end

    always @(posedge i_clk)
        m_tready <= !(snk_idle_on && $urandom_range(99) < IDLE_PCT);

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("acpi_s5_sleep_type_scanner_unit: mismatch");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic last);
        if (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        scan_table_byte(data, last);
    endtask

    task automatic send_table();
        foreach (tbl[i])
            send_byte(tbl[i], i == tbl.size() - 1);
    endtask

    // "DSDT" followed by random header bytes up to HEADER_BYTES
    function automatic void open_table();
        tbl.delete();
        for (int i = 0; i < 4; i++)
            tbl.push_back(SIG_WORD[8*i +: 8]);
        repeat (HEADER_BYTES - 4) tbl.push_back(8'($urandom));
    endfunction

    function automatic void add_fill(input int n);
        repeat (n) tbl.push_back(8'($urandom));
    endfunction

    function automatic void add_s5_word();
        for (int i = 3; i >= 0; i--)
            tbl.push_back(S5_WORD[8*i +: 8]);
    endfunction

    function automatic void add_s5_pkg(input logic [7:0] op, input logic [7:0] len,
                                       input logic [7:0] pfx_a, input logic [7:0] a,
                                       input logic [7:0] pfx_b, input logic [7:0] b);
        add_s5_word();
        tbl.push_back(op);
        tbl.push_back(len);
        tbl.push_back(8'($urandom));
        tbl.push_back(pfx_a);
        tbl.push_back(a);
        tbl.push_back(pfx_b);
        tbl.push_back(b);
    endfunction

    // Fix the byte sum through the header checksum byte, optionally spoil it
    function automatic void seal_table(input bit sum_ok);
        logic [7:0] s = 8'd0;
        if (tbl.size() < 10)
            return;
        foreach (tbl[i])
            s += tbl[i];
        tbl[9] = tbl[9] - s;
        if (!sum_ok)
            tbl[9] = tbl[9] + 8'($urandom_range(1, 255));
    endfunction

    task automatic random_tables(input int min_bytes, input int min_tables);
        int nbytes = 0;
        int ntables = 0;
        int idx;
        while (nbytes < min_bytes || ntables < min_tables) begin
            if ($urandom_range(99) < 85) begin
                open_table();
                add_fill($urandom_range(0, 12));
                if ($urandom_range(3) == 0) begin
                    // decoy match that fails on the package byte or the length
                    add_s5_word();
                    if ($urandom_range(1)) begin
                        tbl.push_back(8'($urandom));
                    end else begin
                        tbl.push_back(PKG_OP);
                        tbl.push_back(8'($urandom_range(0, 3)));
                    end
                    add_fill($urandom_range(0, 3));
                end
                add_s5_pkg(($urandom_range(9) != 0) ? PKG_OP : 8'($urandom),
                           ($urandom_range(7) != 0) ? 8'($urandom_range(4, 255))
                                                    : 8'($urandom_range(0, 3)),
                           ($urandom_range(7) != 0) ? BYTE_PREFIX : 8'($urandom),
                           8'($urandom),
                           ($urandom_range(5) != 0) ? BYTE_PREFIX : 8'($urandom),
                           8'($urandom));
                add_fill($urandom_range(0, 8));
                if ($urandom_range(5) == 0)
                    repeat ($urandom_range(1, 12)) void'(tbl.pop_back());
                if ($urandom_range(19) == 0) begin
                    idx = $urandom_range(3);
                    tbl[idx] = tbl[idx] ^ 8'(1 << $urandom_range(7));
                end
                seal_table($urandom_range(15) != 0);
            end else begin
                tbl.delete();
                repeat ($urandom_range(1, 60)) tbl.push_back(8'($urandom));
                if (tbl.size() >= 4 && $urandom_range(1)) begin
                    for (int i = 0; i < 4; i++)
                        tbl[i] = SIG_WORD[8*i +: 8];
                end
                seal_table($urandom_range(1));
            end
            nbytes += tbl.size();
            ntables++;
            send_table();
        end
    endtask

    task automatic test_short_tables();
        int flip_pos;
        // one to three bytes, then a bare four-byte signature
        for (int n = 1; n <= 4; n++) begin
            tbl.delete();
            for (int i = 0; i < n; i++)
                tbl.push_back(SIG_WORD[8*i +: 8]);
            send_table();
        end
        for (flip_pos = 0; flip_pos < 4; flip_pos++) begin
            open_table();
            add_fill(8);
            tbl[flip_pos] = tbl[flip_pos] ^ 8'($urandom_range(1, 255));
            seal_table(1'b1);
            send_table();
        end
    endtask

    task automatic test_found_variants();
        open_table();
        add_s5_pkg(PKG_OP, 8'hFF, BYTE_PREFIX, 8'h00, BYTE_PREFIX, 8'hFF);
        seal_table(1'b1);
        send_table();
        open_table();
        add_fill(5);
        add_s5_pkg(PKG_OP, LEN_MIN, BYTE_PREFIX, 8'hFF, BYTE_PREFIX, 8'h00);
        add_fill(4);
        seal_table(1'b1);
        send_table();
        // type A only
        open_table();
        add_fill(3);
        add_s5_pkg(PKG_OP, 8'h0A, BYTE_PREFIX, 8'h05, 8'h0B, 8'h07);
        add_fill(2);
        seal_table(1'b1);
        send_table();
        // no prefixed values at all
        open_table();
        add_s5_pkg(PKG_OP, 8'h04, 8'h00, 8'h05, BYTE_PREFIX, 8'h07);
        add_fill(6);
        seal_table(1'b1);
        send_table();
        // package is the very end of the table
        open_table();
        add_fill(1);
        add_s5_pkg(PKG_OP, 8'h80, BYTE_PREFIX, 8'hA5, BYTE_PREFIX, 8'h5A);
        seal_table(1'b1);
        send_table();
    endtask

    task automatic test_search_rules();
        int starts[2] = '{32, 35};
        // window starting inside the header never counts
        foreach (starts[i]) begin
            open_table();
            tbl = tbl[0:starts[i]-1];
            add_s5_pkg(PKG_OP, 8'h10, BYTE_PREFIX, 8'h01, BYTE_PREFIX, 8'h02);
            add_fill(3);
            seal_table(1'b1);
            send_table();
        end
        // failed package byte resumes past the next window
        open_table();
        add_s5_word();
        add_s5_pkg(PKG_OP, 8'h10, BYTE_PREFIX, 8'h03, BYTE_PREFIX, 8'h04);
        seal_table(1'b1);
        send_table();
        // short length: window two bytes on is skipped, three bytes on is taken
        for (int pad = 0; pad < 2; pad++) begin
            open_table();
            add_s5_word();
            tbl.push_back(PKG_OP);
            tbl.push_back(LEN_MIN - 8'd1);
            add_fill(pad);
            add_s5_pkg(PKG_OP, 8'h20, BYTE_PREFIX, 8'h06, BYTE_PREFIX, 8'h07);
            seal_table(1'b1);
            send_table();
        end
        // first success wins
        open_table();
        add_s5_pkg(PKG_OP, 8'h10, BYTE_PREFIX, 8'h11, BYTE_PREFIX, 8'h22);
        add_s5_pkg(PKG_OP, 8'h10, BYTE_PREFIX, 8'h33, BYTE_PREFIX, 8'h44);
        seal_table(1'b1);
        send_table();
        // table cut at every point between the _S5_ word and the package's last byte
        for (int k = 1; k <= 7; k++) begin
            open_table();
            add_fill(2);
            add_s5_pkg(PKG_OP, 8'h10, BYTE_PREFIX, 8'h55, BYTE_PREFIX, 8'h66);
            repeat (k) void'(tbl.pop_back());
            seal_table(1'b1);
            send_table();
        end
    endtask

    task automatic test_status_priority();
        open_table();
        add_fill(10);
        tbl[0] = tbl[0] ^ 8'h01;
        seal_table(1'b0);
        send_table();
        open_table();
        add_s5_pkg(PKG_OP, 8'h10, BYTE_PREFIX, 8'h12, BYTE_PREFIX, 8'h34);
        seal_table(1'b0);
        send_table();
        open_table();
        add_fill(10);
        seal_table(1'b1);
        send_table();
    endtask

    task automatic test_random_traffic();
        random_tables(0, 4);
    endtask

    task automatic test_back_to_back_no_idle();
        src_idle_on = 1'b0;
        snk_idle_on <= 1'b0;
        random_tables(0, 2);
        src_idle_on = 1'b1;
        snk_idle_on <= 1'b1;
    endtask

    initial begin
        clear_scan();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_tables();
        test_found_variants();
        test_search_rules();
        test_status_priority();
        test_random_traffic();
        test_back_to_back_no_idle();

        s_tvalid <= 1'b0;
        while (sleep_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("acpi_s5_sleep_type_scanner_unit: match");
        else
            $display("acpi_s5_sleep_type_scanner_unit: mismatch");
        $finish;
    end

endmodule
